### rtl/ggc_pkg.sv
`default_nettype none

package ggc_pkg;

	// Fixed geometry of the colorer
	localparam int VERT_W       = 6;
	localparam int NUM_VERTICES = 64;
	localparam int CELL_BITS    = 32;
	localparam int NUM_COLORS   = 32;
	localparam int COLOR_W      = 5;
	localparam int CNT_W        = 6;

	// Configuration register indexes
	localparam logic CFG_LINK_BIT   = 1'b0;
	localparam logic CFG_NODE_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE_ROW = 2'd0,
		CMD_CLEAR     = 2'd1,
		CMD_COLOR     = 2'd2,
		CMD_QUERY     = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADJ_RD,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_COUNT,
		ST_RES_RD,
		ST_RESULT
	} state_t;

	// Write request into the color store
	typedef struct packed {
		logic               en;
		logic [VERT_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               valid;
	} color_wr_t;

endpackage

`default_nettype wire

### rtl/greedy_graph_colorer.sv
`default_nettype none

// Channel  Handshake              Payload
// -------  ---------------------  ---------------------------------------------------
// in       in_valid / in_ready    cmd, vertex, word_index, row_bits
// out      out_valid / out_ready  colored, color_index, no_color, colors_used, degree
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Row write, clear, and color or query of an out-of-range vertex: the result is
// read in ST_RES_RD and loaded into the output word in ST_RESULT.
// Query: the row is shifted out one bit per cycle while the color store
// is read at one neighbour per cycle.
// Color: as query, then a search for the lowest free color and an extension of
// the used-color count. One word in flight at a time.
// Reset clears all colors, the used set and out_valid; cfg is always ready.
// A new word is taken while a finished result still waits on out_ready.

module greedy_graph_colorer import ggc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           cmd,
	input  wire logic [VERT_W-1:0]    vertex,
	input  wire logic                 word_index,
	input  wire logic [CELL_BITS-1:0] row_bits,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      colored,
	output logic [COLOR_W-1:0]        color_index,
	output logic                      no_color,
	output logic [CNT_W-1:0]          colors_used,
	output logic [VERT_W-1:0]         degree,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_index,
	input  wire logic [VERT_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	logic                    accept;
	logic                    in_range_in;
	logic                    adj_wr_en;
	logic [2*CELL_BITS-1:0]  adj_row;
	logic [VERT_W-1:0]       col_rd_addr;
	logic [COLOR_W-1:0]      col_rd;
	logic                    col_vld;
	color_wr_t               col_wr;
	logic                    col_clr;
	logic                    pick_hit;
	logic                    pick_miss;
	logic                    count_step;
	logic                    res_load;
	logic                    res_colored;

	// Configuration
	logic                    link_q;
	logic [VERT_W-1:0]       vcount_q;

	// Command context
	cmd_t                    cmd_q;
	logic [VERT_W-1:0]       v_q;
	logic                    in_range_q;

	// Serial scan datapath
	logic [2*CELL_BITS-2:0]  row_sh_q;
	logic [VERT_W-1:0]       n_q;
	logic                    link_s1;
	logic                    scan_s1;
	logic [NUM_COLORS-1:0]   taken_q;
	logic [COLOR_W-1:0]      pick_q;
	logic [VERT_W-1:0]       deg_q;
	logic                    no_color_q;
	logic [NUM_COLORS-1:0]   used_q;
	logic [CNT_W-1:0]        cnt_q;

	// Output word
	logic                    out_valid_q;
	logic                    colored_q;
	logic [COLOR_W-1:0]      color_index_q;
	logic                    out_no_color_q;
	logic [CNT_W-1:0]        colors_used_q;
	logic [VERT_W-1:0]       degree_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign accept      = in_valid && in_ready;
	assign in_range_in = (vertex != '0) && (vertex <= vcount_q);
	assign adj_wr_en   = accept && (cmd_t'(cmd) == CMD_WRITE_ROW);
	assign col_rd_addr = (state_q == ST_SCAN) ? n_q : v_q;
	assign res_colored = col_vld && ((cmd_q == CMD_WRITE_ROW) || in_range_q);

	ggc_adj_store u_adj (
		.clk     (clk),
		.wr_en   (adj_wr_en),
		.wr_addr (vertex),
		.wr_word (word_index),
		.wr_data (row_bits),
		.rd_addr (v_q),
		.rd_row  (adj_row)
	);

	ggc_color_store u_color (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (col_clr),
		.wr       (col_wr),
		.rd_addr  (col_rd_addr),
		.rd_color (col_rd),
		.rd_valid (col_vld)
	);

	// Next state and control
	always_comb begin
		state_d    = state_q;
		col_wr     = '0;
		col_clr    = 1'b0;
		pick_hit   = 1'b0;
		pick_miss  = 1'b0;
		count_step = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (cmd_t'(cmd))
						CMD_WRITE_ROW: state_d = ST_RES_RD;
						CMD_CLEAR: begin
							col_clr = 1'b1;
							state_d = ST_RES_RD;
						end
						CMD_COLOR, CMD_QUERY: begin
							state_d = in_range_in ? ST_ADJ_RD : ST_RES_RD;
						end
					endcase
				end
			end
			ST_ADJ_RD: state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_SCAN;
			ST_SCAN: begin
				if (n_q == vcount_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = (cmd_q == CMD_COLOR) ? ST_PICK : ST_RES_RD;
			ST_PICK: begin
				if (!taken_q[0]) begin
					pick_hit = 1'b1;
					col_wr   = '{en: 1'b1, addr: v_q, color: pick_q, valid: 1'b1};
					state_d  = ST_COUNT;
				end else if (pick_q == COLOR_W'(NUM_COLORS - 1)) begin
					pick_miss = 1'b1;
					col_wr    = '{en: 1'b1, addr: v_q, color: pick_q, valid: 1'b0};
					state_d   = ST_RES_RD;
				end
			end
			ST_COUNT: begin
				if ((cnt_q == CNT_W'(NUM_COLORS)) || !used_q[cnt_q[COLOR_W-1:0]]) begin
					state_d = ST_RES_RD;
				end else begin
					count_step = 1'b1;
				end
			end
			ST_RES_RD: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state, configuration, used set and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			link_q      <= 1'b1;
			vcount_q    <= VERT_W'(NUM_VERTICES - 1);
			scan_s1     <= 1'b0;
			used_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_s1 <= (state_q == ST_SCAN);
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LINK_BIT:   link_q   <= cfg_data[0];
					CFG_NODE_LIMIT: vcount_q <= cfg_data;
				endcase
			end
			if (col_clr) begin
				used_q <= '0;
				cnt_q  <= '0;
			end
			if (pick_hit) begin
				used_q[pick_q] <= 1'b1;
			end
			if (count_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Serial datapath: shift the row out, gather neighbour colors, pick a color
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(cmd);
			v_q        <= vertex;
			in_range_q <= in_range_in;
			taken_q    <= '0;
			deg_q      <= '0;
			no_color_q <= 1'b0;
			pick_q     <= '0;
		end
		// drop bit zero of the row: vertex zero is never a neighbour
		if (state_q == ST_LOAD) begin
			row_sh_q <= adj_row[2*CELL_BITS-1:1];
			n_q      <= VERT_W'(1);
		end
		if (state_q == ST_SCAN) begin
			row_sh_q <= row_sh_q >> 1;
			n_q      <= n_q + VERT_W'(1);
			link_s1  <= (row_sh_q[0] == link_q);
		end
		// color data of the neighbour arrives in the cycle after its row bit
		if (scan_s1 && link_s1) begin
			deg_q <= deg_q + VERT_W'(1);
			if (col_vld) begin
				taken_q[col_rd] <= 1'b1;
			end
		end
		if (state_q == ST_PICK) begin
			taken_q <= taken_q >> 1;
			pick_q  <= pick_q + COLOR_W'(1);
		end
		if (pick_miss) begin
			no_color_q <= 1'b1;
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (res_load) begin
			colored_q      <= res_colored;
			color_index_q  <= res_colored ? col_rd : '0;
			out_no_color_q <= no_color_q;
			colors_used_q  <= cnt_q;
			degree_q       <= (cmd_q == CMD_QUERY) ? deg_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign colored     = colored_q;
	assign color_index = color_index_q;
	assign no_color    = out_no_color_q;
	assign colors_used = colors_used_q;
	assign degree      = degree_q;

endmodule

`default_nettype wire

### rtl/ggc_adj_store.sv
`default_nettype none

module ggc_adj_store import ggc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   wr_en,
	input  wire logic [VERT_W-1:0]      wr_addr,
	input  wire logic                   wr_word,
	input  wire logic [CELL_BITS-1:0]   wr_data,
	input  wire logic [VERT_W-1:0]      rd_addr,
	output logic      [2*CELL_BITS-1:0] rd_row
);

	logic [CELL_BITS-1:0] lo_mem [NUM_VERTICES];
	logic [CELL_BITS-1:0] hi_mem [NUM_VERTICES];
	logic [CELL_BITS-1:0] lo_rd_q;
	logic [CELL_BITS-1:0] hi_rd_q;

	// Write one word of a row, read the whole row registered
	always_ff @(posedge clk) begin
		if (wr_en && !wr_word) begin
			lo_mem[wr_addr] <= wr_data;
		end
		if (wr_en && wr_word) begin
			hi_mem[wr_addr] <= wr_data;
		end
		lo_rd_q <= lo_mem[rd_addr];
		hi_rd_q <= hi_mem[rd_addr];
	end

	assign rd_row = {hi_rd_q, lo_rd_q};

endmodule

`default_nettype wire

### rtl/ggc_color_store.sv
`default_nettype none

module ggc_color_store import ggc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clear,
	input  wire color_wr_t          wr,
	input  wire logic [VERT_W-1:0]  rd_addr,
	output logic      [COLOR_W-1:0] rd_color,
	output logic                    rd_valid
);

	logic [COLOR_W-1:0]      mem [NUM_VERTICES];
	logic [NUM_VERTICES-1:0] vld_q;
	logic [COLOR_W-1:0]      rd_color_q;
	logic                    rd_valid_q;

	// Track which vertices hold a color; clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.addr] <= wr.valid;
			end
			rd_valid_q <= vld_q[rd_addr];
		end
	end

	// Color index memory with registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.color;
		end
		rd_color_q <= mem[rd_addr];
	end

	assign rd_color = rd_color_q;
	assign rd_valid = rd_valid_q;

endmodule

`default_nettype wire

### dv/tb_greedy_graph_colorer.sv
`timescale 1ns / 100ps

module tb_greedy_graph_colorer;
	import ggc_pkg::*;

	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 150;
	localparam int RANDOM_WORDS   = 1700;
	localparam int RANDOM_PHASES  = 8;

	typedef struct packed {
		logic               colored;
		logic [COLOR_W-1:0] color_index;
		logic               no_color;
		logic [CNT_W-1:0]   colors_used;
		logic [VERT_W-1:0]  degree;
	} color_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           cmd;
	logic [VERT_W-1:0]    vertex;
	logic                 word_index;
	logic [CELL_BITS-1:0] row_bits;
	logic                 out_valid;
	logic                 out_ready;
	logic                 colored;
	logic [COLOR_W-1:0]   color_index;
	logic                 no_color;
	logic [CNT_W-1:0]     colors_used;
	logic [VERT_W-1:0]    degree;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_index;
	logic [VERT_W-1:0]    cfg_data;

	// Shadow of the graph, the colors and the registers
	logic [2*CELL_BITS-1:0] adj_rows [NUM_VERTICES];
	logic [VERT_W-1:0]      vertex_colors [NUM_VERTICES];
	logic [NUM_COLORS-1:0]  given_colors;
	logic                   link_value;
	logic [VERT_W-1:0]      vertex_limit;
	bit [1:0]               row_loaded [NUM_VERTICES];

	color_report_t pending_reports[$];
	int            mismatch_count;
	int            stuck_cycles;
	bit            quiet;
	bit            calm;
	bit            hold_request;

	greedy_graph_colorer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.vertex      (vertex),
		.word_index  (word_index),
		.row_bits    (row_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.colored     (colored),
		.color_index (color_index),
		.no_color    (no_color),
		.colors_used (colors_used),
		.degree      (degree),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow state and return its report
	function automatic color_report_t predict_report(cmd_t op, logic [VERT_W-1:0] v,
			logic widx, logic [CELL_BITS-1:0] bits);
		color_report_t         r;
		logic [NUM_COLORS-1:0] taken;
		logic                  in_range;
		int                    n;
		int                    lowest;
		r = '0;
		lowest = 0;
		in_range = (v >= 1) && (v <= vertex_limit);
		case (op)
			CMD_WRITE_ROW: begin
				if (widx)
					adj_rows[v][2*CELL_BITS-1:CELL_BITS] = bits;
				else
					adj_rows[v][CELL_BITS-1:0] = bits;
				row_loaded[v][widx] = 1'b1;
			end
			CMD_CLEAR: begin
				foreach (vertex_colors[i])
					vertex_colors[i] = '0;
				given_colors = '0;
			end
			CMD_COLOR: if (in_range) begin
				// gather neighbour colors; the old own color counts only through a self link
				taken = '0;
				for (n = 1; n <= vertex_limit; n++)
					if (adj_rows[v][n] == link_value && vertex_colors[n] != 0)
						taken[vertex_colors[n] - 1] = 1'b1;
				if (&taken) begin
					r.no_color = 1'b1;
					vertex_colors[v] = '0;
				end else begin
					for (n = NUM_COLORS - 1; n >= 0; n--)
						if (!taken[n])
							lowest = n;
					vertex_colors[v] = VERT_W'(lowest + 1);
					given_colors[lowest] = 1'b1;
				end
			end
			CMD_QUERY: if (in_range) begin
				for (n = 1; n <= vertex_limit; n++)
					if (adj_rows[v][n] == link_value)
						r.degree++;
			end
		endcase
		if ((op == CMD_WRITE_ROW || in_range) && vertex_colors[v] != 0) begin
			r.colored = 1'b1;
			r.color_index = COLOR_W'(vertex_colors[v] - 1);
		end
		for (n = 0; n < NUM_COLORS && given_colors[n]; n++)
			r.colors_used++;
		return r;
	endfunction

	function automatic logic [CELL_BITS-1:0] random_row_bits();
		logic [CELL_BITS-1:0] bits;
		case ($urandom_range(0, 5))
			0: bits = '0;
			1: bits = '1;
			2: bits = $urandom;
			3: bits = $urandom & $urandom & $urandom;
			4: bits = $urandom | $urandom;
			default: bits = 32'h1 << $urandom_range(0, CELL_BITS - 1);
		endcase
		return bits;
	endfunction

	// Offer one word, hold it until accepted, then record its report
	task automatic send_word(cmd_t op, logic [VERT_W-1:0] v, logic widx,
			logic [CELL_BITS-1:0] bits);
		int gap;
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		cmd        <= op;
		vertex     <= v;
		word_index <= widx;
		row_bits   <= bits;
		do @(posedge clk); while (!in_ready);
		pending_reports.push_back(predict_report(op, v, widx, bits));
	endtask

	// Drop valid and wait until every report is back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_reports.size() == 0);
	endtask

	task automatic write_register(logic idx, logic [VERT_W-1:0] data);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_LINK_BIT)
			link_value = data[0];
		else
			vertex_limit = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(logic link, logic [VERT_W-1:0] count);
		logic [VERT_W-1:0] d;
		// upper data bits are don't-care for the link register
		d = VERT_W'($urandom_range(0, 63));
		d[0] = link;
		write_register(CFG_LINK_BIT, d);
		write_register(CFG_NODE_LIMIT, count);
	endtask

	task automatic send_random_word();
		int                   pick;
		cmd_t                 op;
		logic [VERT_W-1:0]    v;
		logic                 widx;
		logic [CELL_BITS-1:0] bits;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 85)
			v = VERT_W'($urandom_range(1, vertex_limit));
		else
			v = VERT_W'($urandom_range(0, NUM_VERTICES - 1));
		widx = ($urandom_range(0, 1) != 0);
		bits = random_row_bits();
		if (pick < 22)
			op = CMD_WRITE_ROW;
		else if (pick < 25)
			op = CMD_CLEAR;
		else if (pick < 72)
			op = CMD_COLOR;
		else
			op = CMD_QUERY;
		// load a row fully before anything reads it
		if ((op == CMD_COLOR || op == CMD_QUERY) && v >= 1 && v <= vertex_limit
				&& row_loaded[v] != 2'b11) begin
			op = CMD_WRITE_ROW;
			widx = row_loaded[v][0];
		end
		send_word(op, v, widx, bits);
	endtask

	// Small hand-built graph: links, recoloring, self links, vertex zero, clear
	task automatic test_directed_basics();
		send_word(CMD_WRITE_ROW, 6'd1, 1'b0, 32'h0000_000C);
		send_word(CMD_WRITE_ROW, 6'd1, 1'b1, 32'h0000_0000);
		send_word(CMD_WRITE_ROW, 6'd2, 1'b0, 32'h0000_000A);
		send_word(CMD_WRITE_ROW, 6'd2, 1'b1, 32'h0000_0000);
		send_word(CMD_WRITE_ROW, 6'd3, 1'b0, 32'h0000_0006);
		send_word(CMD_WRITE_ROW, 6'd3, 1'b1, 32'h0000_0000);
		send_word(CMD_WRITE_ROW, 6'd63, 1'b0, 32'hFFFF_FFFF);
		send_word(CMD_WRITE_ROW, 6'd63, 1'b1, 32'hFFFF_FFFF);
		send_word(CMD_WRITE_ROW, 6'd0, 1'b1, 32'hFFFF_FFFF);
		send_word(CMD_QUERY, 6'd1, 1'b0, '0);
		send_word(CMD_COLOR, 6'd1, 1'b0, '0);
		send_word(CMD_COLOR, 6'd2, 1'b0, '0);
		send_word(CMD_COLOR, 6'd3, 1'b0, '0);
		send_word(CMD_COLOR, 6'd63, 1'b0, '0);
		send_word(CMD_QUERY, 6'd63, 1'b1, '1);
		send_word(CMD_COLOR, 6'd1, 1'b0, '0);
		send_word(CMD_COLOR, 6'd63, 1'b0, '0);
		send_word(CMD_COLOR, 6'd0, 1'b0, '0);
		send_word(CMD_QUERY, 6'd0, 1'b0, '0);
		send_word(CMD_CLEAR, 6'd63, 1'b0, '0);
		send_word(CMD_QUERY, 6'd1, 1'b0, '0);
	endtask

	// Link on zero bits, one vertex in use, vertices above the count
	task automatic test_range_limits();
		apply_setting(1'b0, 6'd1);
		send_word(CMD_COLOR, 6'd1, 1'b0, '0);
		send_word(CMD_COLOR, 6'd2, 1'b0, '0);
		send_word(CMD_QUERY, 6'd2, 1'b0, '0);
		send_word(CMD_QUERY, 6'd1, 1'b0, '0);
		send_word(CMD_COLOR, 6'd1, 1'b0, '0);
		apply_setting(1'b1, 6'd63);
	endtask

	// Fully linked vertices take colors in turn until none is left
	task automatic test_palette_exhaustion();
		send_word(CMD_CLEAR, 6'd5, 1'b0, '0);
		for (int v = 1; v <= NUM_COLORS + 1; v++) begin
			send_word(CMD_WRITE_ROW, VERT_W'(v), 1'b0, '1);
			send_word(CMD_WRITE_ROW, VERT_W'(v), 1'b1, '1);
		end
		for (int v = 1; v <= NUM_COLORS + 1; v++)
			send_word(CMD_COLOR, VERT_W'(v), 1'b0, '0);
		send_word(CMD_QUERY, VERT_W'(NUM_COLORS + 1), 1'b0, '0);
		send_word(CMD_COLOR, 6'd2, 1'b0, '0);
		send_word(CMD_QUERY, 6'd2, 1'b0, '0);
	endtask

	// Stall the result side for a long stretch while words keep coming
	task automatic test_output_backpressure();
		hold_request = 1'b1;
		repeat (12) send_random_word();
	endtask

	// Stop offering until the block has emptied, then resume
	task automatic test_sender_pause();
		repeat (6) send_random_word();
		drain_results();
		repeat (6) send_random_word();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: apply_setting(1'b1, 6'd63);
				1: apply_setting(1'b0, 6'd63);
				2: apply_setting(1'b1, 6'd1);
				3: apply_setting(1'b0, 6'd1);
				4: apply_setting(1'b1, VERT_W'($urandom_range(2, 62)));
				5: apply_setting(1'b0, VERT_W'($urandom_range(2, 62)));
				6: apply_setting(1'b1, VERT_W'($urandom_range(20, 63)));
				default: apply_setting(1'b1, 6'd63);
			endcase
			// no idling at all in the last phase
			if (phase == RANDOM_PHASES - 1)
				quiet = 1'b1;
			repeat (RANDOM_WORDS / RANDOM_PHASES) send_random_word();
		end
	endtask

	// Toggle between stretches with and without idling
	initial begin
		calm = 1'b0;
		forever begin
			repeat ($urandom_range(100, 400)) @(posedge clk);
			calm = !calm;
		end
	end

	// Drive out_ready: long hold on request, short random stalls otherwise
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin
		color_report_t want;
		color_report_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {colored, color_index, no_color, colors_used, degree};
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word %0b/%0d/%0b/%0d/%0d",
						got.colored, got.color_index, got.no_color,
						got.colors_used, got.degree);
			end else begin
				want = pending_reports.pop_front();
				if (got.colored !== want.colored
						|| got.color_index !== want.color_index
						|| got.no_color !== want.no_color
						|| got.colors_used !== want.colors_used
						|| got.degree !== want.degree) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch at %0t: expected %0b/%0d/%0b/%0d/%0d",
							$realtime, want.colored, want.color_index, want.no_color,
							want.colors_used, want.degree,
							" got %0b/%0d/%0b/%0d/%0d", got.colored, got.color_index,
							got.no_color, got.colors_used, got.degree);
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_WRITE_ROW;
		vertex       = '0;
		word_index   = 1'b0;
		row_bits     = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_LINK_BIT;
		cfg_data     = '0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		stuck_cycles = 0;
		mismatch_count = 0;
		given_colors = '0;
		link_value   = 1'b1;
		vertex_limit = 6'd63;
		foreach (adj_rows[i]) begin
			adj_rows[i]      = '0;
			vertex_colors[i] = '0;
			row_loaded[i]    = 2'b00;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_basics();
		test_range_limits();
		test_palette_exhaustion();
		test_output_backpressure();
		test_sender_pause();
		test_random_traffic();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
